FILE: design/lccrld_pkg.sv
// -----------------------------------------------------------------------------
// lccrld_pkg
// Shared types and constants for the letter-count run-length decoder.
// -----------------------------------------------------------------------------
package lccrld_pkg;

    // Longest run that one count can ask for; larger counts saturate here.
    localparam int MAX_RUN = 64;
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam logic [RUN_W-1:0] MAX_RUN_V = RUN_W'(MAX_RUN);

    // Result kinds.
    localparam logic [1:0] KIND_LETTER = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       string_end;
    } lccrld_in_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] letter_out;
        logic       run_last;
        logic       string_done;
    } lccrld_out_t;

    // Work handed from the parser to the run emitter.
    typedef struct packed {
        logic             load;
        logic [1:0]       kind;
        logic [7:0]       letter;
        logic [RUN_W-1:0] count;
        logic             at_end;
    } lccrld_job_t;

    typedef enum logic {
        EMIT_IDLE,
        EMIT_RUN
    } lccrld_emit_state_t;

endpackage

FILE: design/lccrld_parse.sv
// -----------------------------------------------------------------------------
// lccrld_parse
// Character parser: classifies each beat, builds the decimal run count and
// hands finished runs or single status results to the emitter.
// -----------------------------------------------------------------------------
module lccrld_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  lccrld_pkg::lccrld_in_t item,
    output lccrld_pkg::lccrld_job_t job
);

    logic [7:0]                   held_letter_reg, held_letter_next;
    logic                         letter_valid_reg, letter_valid_next;
    logic [lccrld_pkg::RUN_W-1:0] run_count_reg, run_count_next;
    logic                         in_number_reg, in_number_next;
    logic                         discarding_reg, discarding_next;

    logic       is_upper;
    logic       is_lower;
    logic       is_digit;
    logic [3:0] digit;
    logic [9:0] acc;
    logic [lccrld_pkg::RUN_W-1:0] cnt;

    assign is_upper = (item.char_in >= 8'h41) && (item.char_in <= 8'h5A);
    assign is_lower = (item.char_in >= 8'h61) && (item.char_in <= 8'h7A);
    assign is_digit = (item.char_in >= 8'h30) && (item.char_in <= 8'h39);
    assign digit    = 4'(item.char_in - 8'h30);

    // Count times ten as two shifts and an add.
    assign acc = in_number_reg
               ? ({3'b000, run_count_reg} << 3) + ({3'b000, run_count_reg} << 1)
                 + {6'd0, digit}
               : {6'd0, digit};
    assign cnt = (acc > 10'(lccrld_pkg::MAX_RUN)) ? lccrld_pkg::MAX_RUN_V
                                                  : acc[lccrld_pkg::RUN_W-1:0];

    always_comb
    begin
        held_letter_next  = held_letter_reg;
        letter_valid_next = letter_valid_reg;
        run_count_next    = run_count_reg;
        in_number_next    = in_number_reg;
        discarding_next   = discarding_reg;
        job               = '0;

        if (accept)
        begin
            if (discarding_reg)
            begin
                if (item.string_end)
                begin
                    held_letter_next  = '0;
                    letter_valid_next = 1'b0;
                    run_count_next    = '0;
                    in_number_next    = 1'b0;
                    discarding_next   = 1'b0;
                end
            end
            else if (is_digit)
            begin
                if (!in_number_reg && !letter_valid_reg)
                begin
                    // A digit with nothing to count.
                    job.load   = 1'b1;
                    job.kind   = lccrld_pkg::KIND_ERROR;
                    job.count  = lccrld_pkg::RUN_W'(1);
                    job.at_end = item.string_end;
                    if (item.string_end)
                    begin
                        held_letter_next  = '0;
                        letter_valid_next = 1'b0;
                        run_count_next    = '0;
                        in_number_next    = 1'b0;
                    end
                    else
                    begin
                        discarding_next = 1'b1;
                    end
                end
                else if (item.string_end)
                begin
                    job.load   = 1'b1;
                    job.at_end = 1'b1;
                    job.letter = held_letter_reg;
                    if (cnt == '0)
                    begin
                        job.kind   = lccrld_pkg::KIND_END;
                        job.letter = '0;
                        job.count  = lccrld_pkg::RUN_W'(1);
                    end
                    else
                    begin
                        job.kind  = lccrld_pkg::KIND_LETTER;
                        job.count = cnt;
                    end
                    held_letter_next  = '0;
                    letter_valid_next = 1'b0;
                    run_count_next    = '0;
                    in_number_next    = 1'b0;
                end
                else
                begin
                    run_count_next    = cnt;
                    in_number_next    = 1'b1;
                    letter_valid_next = 1'b0;
                end
            end
            else if (item.string_end)
            begin
                // A string may not end on a letter or a separator.
                job.load          = 1'b1;
                job.kind          = lccrld_pkg::KIND_ERROR;
                job.count         = lccrld_pkg::RUN_W'(1);
                job.at_end        = 1'b1;
                held_letter_next  = '0;
                letter_valid_next = 1'b0;
                run_count_next    = '0;
                in_number_next    = 1'b0;
            end
            else
            begin
                if (in_number_reg && (run_count_reg != '0))
                begin
                    job.load   = 1'b1;
                    job.kind   = lccrld_pkg::KIND_LETTER;
                    job.letter = held_letter_reg;
                    job.count  = run_count_reg;
                end
                in_number_next = 1'b0;
                run_count_next = '0;
                if (is_upper || is_lower)
                begin
                    held_letter_next  = is_upper ? (item.char_in | 8'h20) : item.char_in;
                    letter_valid_next = 1'b1;
                end
                else
                begin
                    letter_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg  <= '0;
            letter_valid_reg <= 1'b0;
            run_count_reg    <= '0;
            in_number_reg    <= 1'b0;
            discarding_reg   <= 1'b0;
        end
        else
        begin
            held_letter_reg  <= held_letter_next;
            letter_valid_reg <= letter_valid_next;
            run_count_reg    <= run_count_next;
            in_number_reg    <= in_number_next;
            discarding_reg   <= discarding_next;
        end
    end

endmodule

FILE: design/lccrld_emit.sv
// -----------------------------------------------------------------------------
// lccrld_emit
// Run emitter: a down counter that repeats one result beat per cycle, while the
// result side does not stall, into an output register until the run is exhausted.
// -----------------------------------------------------------------------------
module lccrld_emit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lccrld_pkg::lccrld_job_t job,
    output logic                    busy,
    output logic                    result_valid,
    input  logic                    result_stall,
    output lccrld_pkg::lccrld_out_t result
);

    lccrld_pkg::lccrld_emit_state_t state_reg, state_next;
    logic [lccrld_pkg::RUN_W-1:0]   remain_reg, remain_next;
    logic [1:0]                     kind_reg, kind_next;
    logic [7:0]                     letter_reg, letter_next;
    logic                           at_end_reg, at_end_next;
    logic                           valid_reg, valid_next;
    lccrld_pkg::lccrld_out_t        out_reg, out_next;
    logic                           step;
    logic                           final_beat;

    assign busy         = (state_reg == lccrld_pkg::EMIT_RUN);
    assign result_valid = valid_reg;
    assign result       = out_reg;
    assign final_beat   = (remain_reg == lccrld_pkg::RUN_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        kind_next   = kind_reg;
        letter_next = letter_reg;
        at_end_next = at_end_reg;
        out_next    = out_reg;
        valid_next  = valid_reg && result_stall;
        step        = 1'b0;

        case (state_reg)
            lccrld_pkg::EMIT_IDLE:
            begin
                if (job.load)
                begin
                    state_next  = lccrld_pkg::EMIT_RUN;
                    remain_next = job.count;
                    kind_next   = job.kind;
                    letter_next = job.letter;
                    at_end_next = job.at_end;
                end
            end
            lccrld_pkg::EMIT_RUN:
            begin
                // The output register takes a new beat once the old one has left.
                step = !valid_reg || !result_stall;
                if (step)
                begin
                    valid_next           = 1'b1;
                    out_next.kind        = kind_reg;
                    out_next.letter_out  = letter_reg;
                    out_next.run_last    = final_beat && (kind_reg == lccrld_pkg::KIND_LETTER);
                    out_next.string_done = final_beat && at_end_reg;
                    remain_next          = remain_reg - lccrld_pkg::RUN_W'(1);
                    if (final_beat)
                    begin
                        state_next = lccrld_pkg::EMIT_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = lccrld_pkg::EMIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lccrld_pkg::EMIT_IDLE;
            remain_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        letter_reg <= letter_next;
        at_end_reg <= at_end_next;
        out_reg    <= out_next;
    end

endmodule

FILE: design/letter_count_run_length_decoder_core.sv
// -----------------------------------------------------------------------------
// letter_count_run_length_decoder_core
// Expands letter-count strings such as a3-b12 into runs of lower-case letters.
// -----------------------------------------------------------------------------
//  channel   direction  handshake                    beat
//  item      in         item_valid / item_stall      char_in, string_end
//  result    out        result_valid / result_stall  kind, letter_out, run_last,
//                                                    string_done
//
// A character that causes results holds off the next one through item_stall
// while the run down counter in the emitter repeats its beat; result stalls
// hold it off longer. The output register lets the next character in while the
// last beat waits. Reset clears the parser state and the emitter's state,
// count and valid flag; no clearing pass is needed.
// -----------------------------------------------------------------------------
module letter_count_run_length_decoder_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  lccrld_pkg::lccrld_in_t  item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output lccrld_pkg::lccrld_out_t result
);

    lccrld_pkg::lccrld_job_t job;
    logic                    busy;
    logic                    accept;

    assign item_stall = busy;
    assign accept     = item_valid && !busy;

    lccrld_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .job    (job)
    );

    lccrld_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: tb/letter_count_run_length_decoder_core_tb.sv
// -----------------------------------------------------------------------------
// letter_count_run_length_decoder_core_tb
// Drives letter-count strings through the decoder one character per beat and
// checks every decoded beat against a cycle-free model of the expansion. It
// covers directed format cases, then random well-formed and noise strings,
// with random idle gaps on the items and back-pressure on the results.
// -----------------------------------------------------------------------------
module letter_count_run_length_decoder_core_tb;

    import lccrld_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    lccrld_in_t  item;
    logic        result_valid;
    logic        result_stall;
    lccrld_out_t result;

    letter_count_run_length_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Decoder model state.
    logic [7:0]       pend_letter;
    bit               saw_letter;
    logic [RUN_W-1:0] run_len;
    bit               reading_count;
    bit               skip_rest;

    lccrld_out_t decoded_q [$];
    logic [7:0]  text_q [$];

    int  mismatch_count;
    int  beats_checked;
    int  chars_accepted;
    bit  gaps_on;
    bit  stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #6400000;
        $display("letter_count_run_length_decoder_core_tb: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_decoder();
        pend_letter   = 8'd0;
        saw_letter    = 1'b0;
        run_len       = '0;
        reading_count = 1'b0;
        skip_rest     = 1'b0;
    endfunction

    function automatic void push_beat(logic [1:0] kind, logic [7:0] letter, bit last,
                                      bit done);
        lccrld_out_t b;
        b.kind        = kind;
        b.letter_out  = letter;
        b.run_last    = last;
        b.string_done = done;
        decoded_q.push_back(b);
    endfunction

    function automatic void push_run(bit at_end);
        for (int k = 0; k < int'(run_len); k++)
            push_beat(KIND_LETTER, pend_letter, k == int'(run_len) - 1,
                      (k == int'(run_len) - 1) && at_end);
    endfunction

    task automatic decode_char(input lccrld_in_t beat);
        logic [7:0] c;
        bit         fin;
        bit         upper;
        bit         lower;
        bit         digit;
        int         cnt;
        c     = beat.char_in;
        fin   = beat.string_end;
        upper = (c >= "A") && (c <= "Z");
        lower = (c >= "a") && (c <= "z");
        digit = (c >= "0") && (c <= "9");
        if (skip_rest)
        begin
            if (fin)
                clear_decoder();
            return;
        end
        if (digit)
        begin
            // A digit needs a letter or a digit in front of it.
            if (!reading_count && !saw_letter)
            begin
                push_beat(KIND_ERROR, 8'd0, 1'b0, fin);
                if (fin)
                    clear_decoder();
                else
                    skip_rest = 1'b1;
                return;
            end
            cnt = int'(c) - int'(8'h30);
            if (reading_count)
                cnt = int'(run_len) * 10 + cnt;
            if (cnt > MAX_RUN)
                cnt = MAX_RUN;
            run_len       = RUN_W'(cnt);
            reading_count = 1'b1;
            saw_letter    = 1'b0;
            if (fin)
            begin
                if (run_len == 0)
                    push_beat(KIND_END, 8'd0, 1'b0, 1'b1);
                else
                    push_run(1'b1);
                clear_decoder();
            end
            return;
        end
        // Letter or separator on the last character rejects the string.
        if (fin)
        begin
            push_beat(KIND_ERROR, 8'd0, 1'b0, 1'b1);
            clear_decoder();
            return;
        end
        if (reading_count)
            push_run(1'b0);
        reading_count = 1'b0;
        run_len       = '0;
        if (upper || lower)
        begin
            pend_letter = upper ? c + 8'd32 : c;
            saw_letter  = 1'b1;
        end
        else
            saw_letter = 1'b0;
    endtask

    // ------------------------------------------------------ check and model

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        lccrld_out_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                chars_accepted++;
                decode_char(item);
            end
            if (result_valid && !result_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, got kind %0d letter %h",
                             $time, result.kind, result.letter_out);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    beats_checked++;
                    check_field("kind", 8'(want.kind), 8'(result.kind));
                    check_field("letter_out", want.letter_out, result.letter_out);
                    check_field("run_last", 8'(want.run_last), 8'(result.run_last));
                    check_field("string_done", 8'(want.string_done),
                                8'(result.string_done));
                end
            end
        end
    end

    // Output back-pressure: free stretches between stalls, mostly short ones.
    initial
    begin : stall_gen
        int free_len;
        int hold_len;
        result_stall <= 1'b0;
        forever
        begin
            free_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            repeat (free_len) @(posedge clk);
            if (stalls_on)
            begin
                hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                       : $urandom_range(1, 3);
                result_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------- stimulus

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (!gaps_on || r < 5)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_char(input logic [7:0] c, input bit fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{char_in: c, string_end: fin};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic send_seq();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic send_text(input string txt);
        text_q.delete();
        for (int i = 0; i < txt.len(); i++)
            text_q.push_back(txt[i]);
        send_seq();
    endtask

    task automatic wait_results_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit(int lo);
        return 8'h30 + 8'($urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] rand_separator();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"));
        return c;
    endfunction

    // Well-formed string: runs of letter plus count, last run ends the string.
    task automatic make_good_string();
        int runs;
        int r;
        text_q.delete();
        runs = $urandom_range(1, 4);
        for (int k = 0; k < runs; k++)
        begin
            if (k > 0 && $urandom_range(0, 1))
                text_q.push_back(rand_separator());
            if ($urandom_range(0, 9) == 0)
                text_q.push_back(rand_letter());
            text_q.push_back(rand_letter());
            r = $urandom_range(0, 19);
            if (r == 0)
                text_q.push_back("0");
            else if (r < 15)
                text_q.push_back(rand_digit(1));
            else if (r < 18)
            begin
                text_q.push_back(rand_digit(1));
                text_q.push_back(rand_digit(0));
            end
            else if (r < 19)
            begin
                text_q.push_back(rand_digit(1));
                text_q.push_back(rand_digit(0));
                text_q.push_back(rand_digit(0));
            end
            else
            begin
                text_q.push_back("0");
                text_q.push_back(rand_digit(1));
            end
        end
    endtask

    // Noise string: a mix of letters, digits and arbitrary bytes.
    task automatic make_noise_string();
        int len;
        text_q.delete();
        len = $urandom_range(1, 5);
        repeat (len)
        begin
            case ($urandom_range(0, 2))
                0:       text_q.push_back(rand_letter());
                1:       text_q.push_back(rand_digit(0));
                default: text_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_basic_runs();
        send_text("a3-B12");
    endtask

    task automatic test_count_edges();
        send_text("x0");
        send_text("q999");
    endtask

    task automatic test_format_errors();
        send_text("5");
        send_text("-7z\200");
        send_text("ab2c");
        send_text("Z1\377");
        wait_results_drained();
    endtask

    task automatic test_random_strings();
        int sent;
        sent = 0;
        while (sent < 50)
        begin
            if ($urandom_range(0, 4) == 0)
                make_noise_string();
            else
                make_good_string();
            send_seq();
            sent += text_q.size();
            if ($urandom_range(0, 14) == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (4)
        begin
            make_good_string();
            send_seq();
        end
        wait_results_drained();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        mismatch_count = 0;
        beats_checked  = 0;
        chars_accepted = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        clear_decoder();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_runs();
        test_count_edges();
        test_format_errors();
        test_random_strings();
        test_back_to_back();

        wait_results_drained();
        repeat (30) @(posedge clk);
        $display("Run covered %0d characters and %0d decoded beats: multi-digit and",
                 chars_accepted, beats_checked);
        $display("saturated counts, case folding, stray digits, discarded tails, bad ends.");
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("letter_count_run_length_decoder_core_tb: done, clean");
        else
            $display("letter_count_run_length_decoder_core_tb: done, errors");
        $finish;
    end

endmodule
